// ----- hw/rtl/bis_pkg.sv -----
package bis_pkg;

  // Operation codes of a request.
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LIST   = 2'd2,
    OP_AND    = 2'd3
  } op_e;

  // Control states of the set engine.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_LIST
  } state_e;

  localparam int unsigned ValueW = 16;
  localparam int unsigned IndexW = 11;
  localparam int unsigned MaskW  = 32;
  localparam int unsigned CountW = 17;

  // One request as it arrives on the command port.
  typedef struct packed {
    op_e                operation;
    logic [ValueW-1:0]  value;
    logic [IndexW-1:0]  word_index;
    logic [MaskW-1:0]   mask;
  } req_t;

  // One result as it leaves on the result port.
  typedef struct packed {
    logic               changed;
    logic [ValueW-1:0]  member;
    logic               member_valid;
    logic               last;
    logic [CountW-1:0]  count;
    logic               empty_res;
  } rsp_t;

endpackage

// ----- hw/rtl/bis_ram.sv -----
module bis_ram #(
  parameter int unsigned Depth = 2048,
  parameter int unsigned Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // One write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/bitmap_integer_set.sv -----
// Channel   | Signals                 | Handshake
// ----------+-------------------------+------------------------------------------
// command   | start, req_i, busy      | request taken at an edge with start & !busy
// result    | rsp_valid_o, rsp_o      | one cycle per result, taken at its end
//
// Insert, remove and and first read the word from the bitmap RAM, then
// modify it, write it back and register the result.
// List reads the word the same way, then peels off the lowest remaining
// member each cycle, one result per member (a single result when the word
// is empty). Results show in the cycle after they are formed.
// After reset busy stays high while a clearing pass zeroes all NumWords
// words of the bitmap (2048 by default). Results cannot be stalled.
// WORD_BITS must be a power of two.
module bitmap_integer_set #(
  parameter int unsigned VALUE_BITS = 16,
  parameter int unsigned WORD_BITS  = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  bis_pkg::req_t req_i,
  output logic          busy,
  output logic          rsp_valid_o,
  output bis_pkg::rsp_t rsp_o
);
  import bis_pkg::*;

  localparam int unsigned NumWords = (2 ** VALUE_BITS) / WORD_BITS;
  localparam int unsigned AddrW    = $clog2(NumWords);
  localparam int unsigned BitW     = $clog2(WORD_BITS);
  localparam int unsigned PopW     = BitW + 1;
  localparam int unsigned CntW     = VALUE_BITS + 1;

  // Population count as a tree of pairwise sums.
  function automatic logic [PopW-1:0] pop_word(input logic [WORD_BITS-1:0] w);
    logic [PopW-1:0] acc [WORD_BITS];
    for (int i = 0; i < WORD_BITS; i++) begin
      acc[i] = PopW'(w[i]);
    end
    for (int s = 1; s < WORD_BITS; s = s * 2) begin
      for (int i = 0; i < WORD_BITS; i = i + 2 * s) begin
        acc[i] = acc[i] + acc[i+s];
      end
    end
    return acc[0];
  endfunction

  state_e state_q, state_d;
  req_t   req_q;
  logic [AddrW-1:0]     addr_q, addr_in;
  logic                 idx_ok_q, idx_ok_in;
  logic [AddrW-1:0]     clr_q, clr_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [WORD_BITS-1:0] list_q, list_d;
  logic                 rsp_valid_q, rsp_valid_d;
  rsp_t                 rsp_q, rsp_d;

  logic                 accept;
  logic                 ram_we;
  logic [AddrW-1:0]     ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_rdata;

  logic [VALUE_BITS-1:0] val_in, val_q;
  logic [WORD_BITS-1:0]  bit_sel;
  logic [WORD_BITS-1:0]  mask_w;
  logic                  present;
  logic [WORD_BITS-1:0]  low_bit;
  logic [BitW-1:0]       low_idx;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);

  // Address of the word a new request touches.
  assign val_in    = VALUE_BITS'(req_i.value);
  assign idx_ok_in = (32'(req_i.word_index) < NumWords);
  always_comb begin
    addr_in = '0;
    if (req_i.operation == OP_INSERT || req_i.operation == OP_REMOVE) begin
      addr_in = val_in[VALUE_BITS-1:BitW];
    end else if (idx_ok_in) begin
      addr_in = AddrW'(req_i.word_index);
    end
  end

  // State, counters and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q    <= req_i;
      addr_q   <= addr_in;
      idx_ok_q <= idx_ok_in;
    end
    list_q <= list_d;
    rsp_q  <= rsp_d;
  end

  // Bit and mask of the request under execution.
  assign val_q   = VALUE_BITS'(req_q.value);
  assign bit_sel = WORD_BITS'(1) << val_q[BitW-1:0];
  assign mask_w  = WORD_BITS'(req_q.mask);
  assign present = |(ram_rdata & bit_sel);

  // Lowest member still to be listed.
  assign low_bit = list_q & (~list_q + WORD_BITS'(1));
  always_comb begin
    low_idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (low_bit[i]) begin
        low_idx = low_idx | BitW'(i);
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_q == AddrW'(NumWords - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (start) state_d = ST_EXEC;
      ST_EXEC: begin
        if (req_q.operation == OP_LIST && idx_ok_q && ram_rdata != '0) begin
          state_d = ST_LIST;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_LIST:  if (list_d == '0) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath and result formation.
  always_comb begin
    clr_d       = clr_q;
    cnt_d       = cnt_q;
    list_d      = list_q;
    ram_we      = 1'b0;
    ram_waddr   = addr_q;
    ram_wdata   = ram_rdata;
    rsp_valid_d = 1'b0;
    rsp_d       = '0;
    rsp_d.last  = 1'b1;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + AddrW'(1);
      end
      ST_EXEC: begin
        rsp_valid_d = 1'b1;
        case (req_q.operation)
          OP_INSERT: begin
            rsp_d.changed = !present;
            ram_we        = !present;
            ram_wdata     = ram_rdata | bit_sel;
            if (!present) cnt_d = cnt_q + CntW'(1);
          end
          OP_REMOVE: begin
            rsp_d.changed = present;
            ram_we        = present;
            ram_wdata     = ram_rdata & ~bit_sel;
            if (present) cnt_d = cnt_q - CntW'(1);
          end
          OP_AND: begin
            ram_we    = idx_ok_q;
            ram_wdata = ram_rdata & mask_w;
            if (idx_ok_q) cnt_d = cnt_q - CntW'(pop_word(ram_rdata & ~mask_w));
          end
          OP_LIST: begin
            if (idx_ok_q && ram_rdata != '0) begin
              rsp_valid_d = 1'b0;
              list_d      = ram_rdata;
            end
          end
          default: rsp_valid_d = 1'b0;
        endcase
      end
      ST_LIST: begin
        list_d             = list_q & ~low_bit;
        rsp_valid_d        = 1'b1;
        rsp_d.member       = ValueW'({req_q.word_index, low_idx});
        rsp_d.member_valid = 1'b1;
        rsp_d.last         = (list_d == '0);
      end
      default: ;
    endcase
    rsp_d.count     = CountW'(cnt_d);
    rsp_d.empty_res = (cnt_d == '0);
  end

  bis_ram #(
    .Depth (NumWords),
    .Width (WORD_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (addr_in),
    .rdata_o (ram_rdata)
  );

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // A non-list request gives its final result after ST_EXEC and the result register.
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.operation != OP_LIST) |-> ##2 (rsp_valid_o && rsp_o.last))
    else $error("single-result request did not complete in two cycles");

  // The final result of a request frees the command port.
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.last) |-> !busy)
    else $error("busy still high with final result");

  // A non-final result only appears while a list is in progress.
  a_mid_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && !rsp_o.last) |-> (busy && rsp_o.member_valid))
    else $error("non-final result outside a list");

  // The member count never exceeds the value range.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(cnt_q) <= (2 ** VALUE_BITS)))
    else $error("member count out of range");

endmodule
